// File: rtl/keystroke_line_editor_with_history_defines.svh
// assertion macros for the keystroke line editor
// used at the end of the top level; expects clk and arst_n in scope
`ifndef KEYSTROKE_LINE_EDITOR_WITH_HISTORY_DEFINES_SVH
`define KEYSTROKE_LINE_EDITOR_WITH_HISTORY_DEFINES_SVH

// same-cycle implication
`define KLED_AST_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("kled check failed");

// next-cycle implication
`define KLED_AST_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("kled check failed");

`endif

// File: rtl/kled_pkg.sv
// constants shared by the keystroke line editor
// key codes, field widths and parameter defaults; no dependencies
package kled_pkg;
	localparam int KEY_W = 10;
	localparam int CHAR_W = 7;
	localparam int CAP_W = 7;
	localparam int LINE_CHARS_DEF = 64;
	localparam int HISTORY_SLOTS_DEF = 8;
	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;
	localparam logic [CHAR_W-1:0] CH_SPACE = 7'd32;

	localparam logic [KEY_W-1:0] K_CTRL_C = 10'd3;
	localparam logic [KEY_W-1:0] K_BACKSPACE = 10'd8;
	localparam logic [KEY_W-1:0] K_ENTER = 10'd13;
	localparam logic [KEY_W-1:0] K_CTRL_U = 10'd21;
	localparam logic [KEY_W-1:0] K_CTRL_W = 10'd23;
	localparam logic [KEY_W-1:0] K_PRINT_LO = 10'd32;
	localparam logic [KEY_W-1:0] K_PRINT_HI = 10'd126;
	localparam logic [KEY_W-1:0] K_UP = 10'd1001;
	localparam logic [KEY_W-1:0] K_DOWN = 10'd1002;
	localparam logic [KEY_W-1:0] K_LEFT = 10'd1003;
	localparam logic [KEY_W-1:0] K_RIGHT = 10'd1004;
	localparam logic [KEY_W-1:0] K_HOME = 10'd1005;
	localparam logic [KEY_W-1:0] K_END = 10'd1006;
	localparam logic [KEY_W-1:0] K_DELETE = 10'd1007;
endpackage

// File: rtl/keystroke_line_editor_with_history.sv
// line editor with cursor and history; one key item at a time
// steps: cursor moves and clears are done in idle; insert/delete read and write each shifted char,
// ctrl-w first reads and checks each scanned char; recall reads and writes each copied char;
// enter reads, loads and holds each emitted char until the receiver takes it
// throughput: next key taken once the current one is fully done (in_ready in idle)
// reset: async, clears length, cursor, history count and recall position; rams not cleared
module keystroke_line_editor_with_history #(
	parameter int LINE_CHARS = kled_pkg::LINE_CHARS_DEF,
	parameter int HISTORY_SLOTS = kled_pkg::HISTORY_SLOTS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [kled_pkg::KEY_W-1:0]  key_code,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [kled_pkg::CHAR_W-1:0] out_char,
	output logic                        last_of_line,
	output logic                        line_empty,
	output logic                        cancelled,
	input  logic                        cfg_we,
	input  logic [kled_pkg::CAP_W-1:0]  cfg_wdata
);
	import kled_pkg::*;
	`include "keystroke_line_editor_with_history_defines.svh"

	localparam int IW = $clog2(LINE_CHARS);
	localparam int HW = $clog2(HISTORY_SLOTS);
	localparam int HAW = $clog2(HISTORY_SLOTS * LINE_CHARS);
	localparam logic [IW-1:0] LEN_MAX = IW'(LINE_CHARS - 1);
	localparam logic [HW-1:0] USED_MAX = HW'(HISTORY_SLOTS - 1);
	localparam logic [HW:0] SLOTS_X = (HW+1)'(HISTORY_SLOTS);
	localparam logic [HAW-1:0] LC_H = HAW'(LINE_CHARS);

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_INS_RD   = 4'd1;
	localparam logic [3:0] S_INS_WR   = 4'd2;
	localparam logic [3:0] S_SCAN_RD  = 4'd3;
	localparam logic [3:0] S_SCAN_CK  = 4'd4;
	localparam logic [3:0] S_DEL_RD   = 4'd5;
	localparam logic [3:0] S_DEL_WR   = 4'd6;
	localparam logic [3:0] S_REC_RD   = 4'd7;
	localparam logic [3:0] S_REC_WR   = 4'd8;
	localparam logic [3:0] S_OUT_RD   = 4'd9;
	localparam logic [3:0] S_OUT_LD   = 4'd10;
	localparam logic [3:0] S_OUT_WAIT = 4'd11;

	logic [3:0]        state_q;
	logic [CAP_W-1:0]  cap_q;
	logic [IW-1:0]     len_q, cur_q, pos_q, dst_q, src_q, n_q, rlen_q;
	logic [HW-1:0]     used_q, rp_q, base_q, slot_q;
	logic              word_q, store_q;
	logic [CHAR_W-1:0] key_q;
	logic [IW-1:0]     hlen_q [HISTORY_SLOTS];
	logic              out_valid_q, last_q, empty_q, canc_q;
	logic [CHAR_W-1:0] out_char_q;

	logic              line_we;
	logic [IW-1:0]     line_waddr, line_raddr;
	logic [CHAR_W-1:0] line_wdata, line_rdata;
	logic              hist_we;
	logic [HAW-1:0]    hist_waddr, hist_raddr;
	logic [CHAR_W-1:0] hist_rdata;

	logic              in_acc, out_acc;
	logic [HW:0]       rp_try;
	logic [HW-1:0]     rp_new;
	logic [CAP_W-1:0]  cap_eff, cap_m1, len_x, n_x;

	function automatic logic [HW-1:0] phys(input logic [HW-1:0] base, input logic [HW-1:0] i);
		logic [HW:0] s;
		s = {1'b0, base} + {1'b0, i};
		if (s >= SLOTS_X) begin
			s = s - SLOTS_X;
		end
		return s[HW-1:0];
	endfunction

	assign in_ready = (state_q == S_IDLE);
	assign in_acc = in_valid && in_ready;
	assign out_acc = out_valid_q && out_ready;
	assign out_valid = out_valid_q;
	assign out_char = out_char_q;
	assign last_of_line = last_q;
	assign line_empty = empty_q;
	assign cancelled = canc_q;

	// recall target, clamped to the stored range
	always_comb begin
		if (key_code == K_UP) begin
			rp_try = (rp_q != '0) ? {1'b0, rp_q} - 1'b1 : {1'b0, rp_q};
		end else begin
			rp_try = {1'b0, rp_q} + 1'b1;
		end
		rp_new = (rp_try >= {1'b0, used_q}) ? used_q - 1'b1 : rp_try[HW-1:0];
	end

	// emitted count: min(length, capacity-1), capacity 0 acts as 1
	always_comb begin
		cap_eff = (cap_q == '0) ? CAP_W'(1) : cap_q;
		cap_m1 = cap_eff - 1'b1;
		len_x = CAP_W'(len_q);
		n_x = (len_x < cap_m1) ? len_x : cap_m1;
	end

	always_comb begin
		line_we = 1'b0;
		line_waddr = '0;
		line_wdata = '0;
		line_raddr = '0;
		hist_we = 1'b0;
		hist_waddr = '0;
		hist_raddr = '0;
		unique case (state_q)
			S_INS_RD: begin
				if (pos_q > cur_q) begin
					line_raddr = pos_q - 1'b1;
				end else begin
					line_we = 1'b1;
					line_waddr = cur_q;
					line_wdata = key_q;
				end
			end
			S_INS_WR: begin
				line_we = 1'b1;
				line_waddr = pos_q;
				line_wdata = line_rdata;
			end
			S_SCAN_RD: line_raddr = pos_q - 1'b1;
			S_DEL_RD: line_raddr = src_q;
			S_DEL_WR: begin
				line_we = 1'b1;
				line_waddr = dst_q;
				line_wdata = line_rdata;
			end
			S_REC_RD: hist_raddr = HAW'(slot_q) * LC_H + HAW'(dst_q);
			S_REC_WR: begin
				line_we = 1'b1;
				line_waddr = dst_q;
				line_wdata = hist_rdata;
			end
			S_OUT_RD: line_raddr = dst_q;
			S_OUT_LD: begin
				hist_we = 1'b1;
				hist_waddr = HAW'(slot_q) * LC_H + HAW'(dst_q);
			end
			default: begin
			end
		endcase
	end

	kled_ram #(.WIDTH(CHAR_W), .DEPTH(LINE_CHARS)) u_line_ram (
		.clk  (clk),
		.we   (line_we),
		.waddr(line_waddr),
		.wdata(line_wdata),
		.raddr(line_raddr),
		.rdata(line_rdata)
	);

	kled_ram #(.WIDTH(CHAR_W), .DEPTH(HISTORY_SLOTS * LINE_CHARS)) u_hist_ram (
		.clk  (clk),
		.we   (hist_we),
		.waddr(hist_waddr),
		.wdata(line_rdata),
		.raddr(hist_raddr),
		.rdata(hist_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	// history lengths, written once per stored line
	always_ff @(posedge clk) begin
		if (state_q == S_OUT_WAIT && out_acc && dst_q == n_q && store_q) begin
			hlen_q[slot_q] <= n_q;
		end
	end

	// payload and scratch registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_acc) begin
			key_q <= key_code[CHAR_W-1:0];
			unique case (key_code)
				K_ENTER: begin
					n_q <= IW'(n_x);
					dst_q <= '0;
					slot_q <= phys(base_q, used_q);
					store_q <= (n_x != '0);
					out_char_q <= '0;
					last_q <= 1'b1;
					empty_q <= 1'b1;
					canc_q <= 1'b0;
				end
				K_CTRL_C: begin
					n_q <= '0;
					dst_q <= '0;
					store_q <= 1'b0;
					out_char_q <= '0;
					last_q <= 1'b1;
					empty_q <= 1'b1;
					canc_q <= 1'b1;
				end
				K_CTRL_W: begin
					pos_q <= cur_q;
					word_q <= 1'b0;
				end
				K_BACKSPACE: begin
					pos_q <= cur_q - 1'b1;
					dst_q <= cur_q - 1'b1;
					src_q <= cur_q;
				end
				K_DELETE: begin
					pos_q <= cur_q;
					dst_q <= cur_q;
					src_q <= cur_q + 1'b1;
				end
				K_UP, K_DOWN: begin
					slot_q <= phys(base_q, rp_new);
					rlen_q <= hlen_q[phys(base_q, rp_new)];
					dst_q <= '0;
				end
				default: pos_q <= len_q;
			endcase
		end else begin
			case (state_q)
				S_INS_WR: pos_q <= pos_q - 1'b1;
				S_SCAN_CK: begin
					if (!word_q && line_rdata != CH_SPACE) begin
						word_q <= 1'b1;
						pos_q <= pos_q - 1'b1;
					end else if (word_q && line_rdata == CH_SPACE) begin
						dst_q <= pos_q;
						src_q <= cur_q;
					end else begin
						pos_q <= pos_q - 1'b1;
					end
				end
				S_SCAN_RD: begin
					if (pos_q == '0) begin
						dst_q <= pos_q;
						src_q <= cur_q;
					end
				end
				S_DEL_WR: begin
					dst_q <= dst_q + 1'b1;
					src_q <= src_q + 1'b1;
				end
				S_REC_WR: dst_q <= dst_q + 1'b1;
				S_OUT_LD: begin
					out_char_q <= line_rdata;
					last_q <= (dst_q + 1'b1 == n_q);
					empty_q <= 1'b0;
					canc_q <= 1'b0;
					dst_q <= dst_q + 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			len_q <= '0;
			cur_q <= '0;
			used_q <= '0;
			rp_q <= '0;
			base_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						unique case (key_code)
							K_ENTER: state_q <= (n_x != '0) ? S_OUT_RD : S_OUT_WAIT;
							K_CTRL_C: state_q <= S_OUT_WAIT;
							K_CTRL_U: begin
								len_q <= '0;
								cur_q <= '0;
							end
							K_CTRL_W: state_q <= S_SCAN_RD;
							K_BACKSPACE: begin
								if (cur_q != '0) begin
									state_q <= S_DEL_RD;
								end
							end
							K_DELETE: begin
								if (cur_q < len_q) begin
									state_q <= S_DEL_RD;
								end
							end
							K_LEFT: begin
								if (cur_q != '0) begin
									cur_q <= cur_q - 1'b1;
								end
							end
							K_RIGHT: begin
								if (cur_q < len_q) begin
									cur_q <= cur_q + 1'b1;
								end
							end
							K_HOME: cur_q <= '0;
							K_END: cur_q <= len_q;
							K_UP, K_DOWN: begin
								if (used_q != '0) begin
									rp_q <= rp_new;
									state_q <= S_REC_RD;
								end
							end
							default: begin
								if (key_code >= K_PRINT_LO && key_code <= K_PRINT_HI
									&& len_q < LEN_MAX) begin
									state_q <= S_INS_RD;
								end
							end
						endcase
						if (key_code == K_ENTER || key_code == K_CTRL_C) begin
							out_valid_q <= (key_code == K_CTRL_C) || (n_x == '0);
						end
					end
				end
				S_INS_RD: begin
					if (pos_q > cur_q) begin
						state_q <= S_INS_WR;
					end else begin
						len_q <= len_q + 1'b1;
						cur_q <= cur_q + 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_INS_WR: state_q <= S_INS_RD;
				S_SCAN_RD: state_q <= (pos_q == '0) ? S_DEL_RD : S_SCAN_CK;
				S_SCAN_CK: begin
					// spaces first, then the word; stop at a space after the word
					if (word_q && line_rdata == CH_SPACE) begin
						state_q <= S_DEL_RD;
					end else begin
						state_q <= S_SCAN_RD;
					end
				end
				S_DEL_RD: begin
					if (src_q < len_q) begin
						state_q <= S_DEL_WR;
					end else begin
						len_q <= dst_q;
						cur_q <= pos_q;
						state_q <= S_IDLE;
					end
				end
				S_DEL_WR: state_q <= S_DEL_RD;
				S_REC_RD: begin
					if (dst_q < rlen_q) begin
						state_q <= S_REC_WR;
					end else begin
						len_q <= rlen_q;
						cur_q <= rlen_q;
						state_q <= S_IDLE;
					end
				end
				S_REC_WR: state_q <= S_REC_RD;
				S_OUT_RD: state_q <= S_OUT_LD;
				S_OUT_LD: begin
					out_valid_q <= 1'b1;
					state_q <= S_OUT_WAIT;
				end
				S_OUT_WAIT: begin
					if (out_acc) begin
						out_valid_q <= 1'b0;
						if (dst_q == n_q) begin
							len_q <= '0;
							cur_q <= '0;
							state_q <= S_IDLE;
							if (!store_q) begin
								rp_q <= used_q;
							end else if (used_q == USED_MAX) begin
								// full: newest took the free slot, oldest drops out
								base_q <= (base_q == USED_MAX) ? '0 : base_q + 1'b1;
								rp_q <= used_q;
							end else begin
								used_q <= used_q + 1'b1;
								rp_q <= used_q + 1'b1;
							end
						end else begin
							state_q <= S_OUT_RD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`KLED_AST_IMP(a_cur_in_line, 1'b1, cur_q <= len_q && len_q <= LEN_MAX)
	`KLED_AST_IMP(a_ready_no_out, in_ready, !out_valid)
	`KLED_AST_IMP(a_recall_range, 1'b1, rp_q <= used_q && used_q <= USED_MAX)
	`KLED_AST_NXT(a_out_clears, out_valid && out_ready, !out_valid)
endmodule

// File: rtl/kled_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module kled_ram #(
	parameter int WIDTH = 7,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
